FILE: hw/rtl/tmhq_pkg.sv
`timescale 1ns / 1ps

package tmhq_pkg;

   // Field widths of the item and result ports.
   localparam int FUNC_W    = 2;
   localparam int KEY_W     = 32;
   localparam int POS_W     = 7;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 8;

   // Default number of keys the heap can hold.
   localparam int CAPACITY_DEF = 128;

   // Operation codes of an input item.
   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT   = 2'd0,
      FN_EXTRACT  = 2'd1,
      FN_DECREASE = 2'd2,
      FN_NOP      = 2'd3
   } func_type;

   // Status codes of a result item.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // Source of the heap read address.
   typedef enum logic [2:0] {
      RD_ROOT,
      RD_LAST,
      RD_POS,
      RD_PARENT,
      RD_FIRST,
      RD_NEXT
   } rd_sel_type;

   // Source of the heap write data; the write address is always the hole.
   typedef enum logic [1:0] {
      WR_KEY,
      WR_RDATA,
      WR_BEST
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;          // capture the item fields
      logic       set_status;    // overwrite the status with status
      status_type status;
      logic       insert_setup;  // hole at the old count, count up
      logic       ex_root;       // take the read data as the result key
      logic       ex_last;       // last entry becomes the moving key, count down
      logic       dec_setup;     // hole at the item position
      logic       par_calc;      // register the parent index of the hole
      logic       child_first;   // start the child scan at the first child
      logic       child_next;    // advance the child scan
      logic       best_upd;      // fold the read child into the best child
      logic       move_up;       // hole moves to its parent
      logic       move_down;     // hole moves to the best child
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       respond;       // present the result item next cycle
   } cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     pos_bad;
      logic     rdata_lt_key;
      logic     key_lt_rdata;
      logic     cur_zero;
      logic     first_past_end;
      logic     more_child;
      logic     best_lt_key;
   } stat_type;

endpackage

FILE: hw/rtl/tmhq_ram.sv
`timescale 1ns / 1ps

module tmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tmhq_dp.sv
`timescale 1ns / 1ps

module tmhq_dp #(
   parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tmhq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tmhq_pkg::KEY_W-1:0]    req_key,
   input  logic [tmhq_pkg::POS_W-1:0]           req_position,
   input  tmhq_pkg::cmd_type                    cmd,
   output tmhq_pkg::stat_type                   stat,
   output logic                                 rsp_valid,
   output logic signed [tmhq_pkg::KEY_W-1:0]    rsp_result_key,
   output logic [tmhq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tmhq_pkg::ENTRIES_W-1:0]       rsp_entries
);

   import tmhq_pkg::*;

   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CHD_W     = IDX_W + 2;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DIV_S     = IDX_W + 2;
   localparam int DIV_M     = (2 ** DIV_S) / 3;
   localparam int PROD_W    = IDX_W + DIV_S;
   localparam int KIDX_LAST = 2;

   // Item and working registers.
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [KEY_W-1:0]        result_ff, result_in;
   status_type              status_ff, status_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [IDX_W-1:0]        parent_ff, parent_in;
   logic [CHD_W-1:0]        child_ff, child_in;
   logic [1:0]              kidx_ff, kidx_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic signed [KEY_W-1:0] best_key_ff, best_key_in;
   logic                    rsp_valid_ff;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [ENTRIES_W-1:0]    rsp_entries_ff;

   // Heap memory interface.
   logic [IDX_W-1:0]        rd_addr;
   logic [KEY_W-1:0]        rd_data;
   logic [KEY_W-1:0]        wr_data;

   // Index arithmetic.
   logic [IDX_W-1:0]        up_x;
   logic [PROD_W-1:0]       par_prod;
   logic [IDX_W-1:0]        par_q0;
   logic [IDX_W+1:0]        par_three;
   logic [IDX_W+1:0]        par_rem;
   logic [IDX_W-1:0]        par_q;
   logic [CHD_W-1:0]        first_idx;
   logic [CHD_W-1:0]        child_nx;
   logic [CHD_W-1:0]        count_chd;

   tmhq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_heap (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cur_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Parent of the hole, (cur - 1) / 3, by a reciprocal multiply and one correction.
   assign up_x      = cur_ff - IDX_W'(1);
   assign par_prod  = PROD_W'(up_x) * PROD_W'(DIV_M);
   assign par_q0    = par_prod[PROD_W-1 -: IDX_W];
   assign par_three = ((IDX_W + 2)'(par_q0) << 1) + (IDX_W + 2)'(par_q0);
   assign par_rem   = (IDX_W + 2)'(up_x) - par_three;
   assign par_q     = (par_rem >= (IDX_W + 2)'(3)) ? par_q0 + IDX_W'(1) : par_q0;

   // First child of the hole and the next child in the scan.
   assign first_idx = (CHD_W'(cur_ff) << 1) + CHD_W'(cur_ff) + CHD_W'(1);
   assign child_nx  = child_ff + CHD_W'(1);
   assign count_chd = CHD_W'(count_ff);

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT:   rd_addr = '0;
         RD_LAST:   rd_addr = IDX_W'(count_ff - CNT_W'(1));
         RD_POS:    rd_addr = IDX_W'(pos_ff);
         RD_PARENT: rd_addr = parent_ff;
         RD_FIRST:  rd_addr = IDX_W'(first_idx);
         RD_NEXT:   rd_addr = IDX_W'(child_nx);
         default:   rd_addr = '0;
      endcase
   end

   // Write data selection.
   always_comb begin
      case (cmd.wr_sel)
         WR_KEY:   wr_data = key_ff;
         WR_RDATA: wr_data = rd_data;
         WR_BEST:  wr_data = best_key_ff;
         default:  wr_data = key_ff;
      endcase
   end

   // Status flags for the controller.
   always_comb begin
      stat.func           = func_type'(func_ff);
      stat.full           = (count_ff == CNT_W'(CAPACITY));
      stat.empty          = (count_ff == '0);
      stat.pos_bad        = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
      stat.rdata_lt_key   = ($signed(rd_data) < key_ff);
      stat.key_lt_rdata   = (key_ff < $signed(rd_data));
      stat.cur_zero       = (cur_ff == '0);
      stat.first_past_end = (first_idx >= count_chd);
      stat.more_child     = (kidx_ff != 2'(KIDX_LAST)) && (child_nx < count_chd);
      stat.best_lt_key    = (best_key_ff < key_ff);
   end

   // Next values of the working registers.
   always_comb begin
      func_in     = func_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      result_in   = result_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      parent_in   = parent_ff;
      child_in    = child_ff;
      kidx_in     = kidx_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;

      if (cmd.load) begin
         func_in   = req_func;
         key_in    = req_key;
         pos_in    = req_position;
         result_in = '0;
         status_in = ST_OK;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.insert_setup) begin
         cur_in   = IDX_W'(count_ff);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.ex_root) begin
         result_in = rd_data;
      end
      if (cmd.ex_last) begin
         key_in   = $signed(rd_data);
         count_in = count_ff - CNT_W'(1);
         cur_in   = '0;
      end
      if (cmd.dec_setup) begin
         cur_in = IDX_W'(pos_ff);
      end
      if (cmd.par_calc) begin
         parent_in = par_q;
      end
      if (cmd.child_first) begin
         child_in = first_idx;
         kidx_in  = '0;
      end
      if (cmd.child_next) begin
         child_in = child_nx;
         kidx_in  = kidx_ff + 2'(1);
      end
      if (cmd.best_upd) begin
         // The first child always seeds the scan; later ones win only when strictly smaller.
         if ((kidx_ff == '0) || ($signed(rd_data) < best_key_ff)) begin
            best_key_in = $signed(rd_data);
            best_idx_in = IDX_W'(child_ff);
         end
      end
      if (cmd.move_up) begin
         cur_in = parent_ff;
      end
      if (cmd.move_down) begin
         cur_in = best_idx_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      cur_ff      <= cur_in;
      parent_ff   <= parent_in;
      child_ff    <= child_in;
      kidx_ff     <= kidx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      if (cmd.respond) begin
         rsp_key_ff     <= result_ff;
         rsp_status_ff  <= status_ff;
         rsp_entries_ff <= ENTRIES_W'(count_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_key = $signed(rsp_key_ff);
   assign rsp_status     = rsp_status_ff;
   assign rsp_entries    = rsp_entries_ff;

endmodule

FILE: hw/rtl/tmhq_ctrl.sv
`timescale 1ns / 1ps

module tmhq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tmhq_pkg::stat_type stat,
   output tmhq_pkg::cmd_type  cmd
);

   import tmhq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EX_ROOT,
      S_EX_LAST,
      S_DN_FIRST,
      S_DN_CHILD,
      S_DN_DECIDE,
      S_DEC_CMP,
      S_UP_CHECK,
      S_UP_RD,
      S_UP_CMP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FN_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_DONE;
                  end else begin
                     cmd.insert_setup = 1'b1;
                     state_in         = S_UP_CHECK;
                  end
               end
               FN_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ROOT;
                     state_in   = S_EX_ROOT;
                  end
               end
               FN_DECREASE: begin
                  if (stat.pos_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_IGNORED;
                     state_in       = S_DONE;
                  end else begin
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = RD_POS;
                     cmd.dec_setup = 1'b1;
                     state_in      = S_DEC_CMP;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // Extract: take the root, then the last entry becomes the moving key.
         S_EX_ROOT: begin
            cmd.ex_root = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LAST;
            state_in    = S_EX_LAST;
         end
         S_EX_LAST: begin
            cmd.ex_last = 1'b1;
            state_in    = S_DN_FIRST;
         end
         // Sift down: scan up to three children, then move the hole or settle.
         S_DN_FIRST: begin
            if (stat.first_past_end) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end else begin
               cmd.rd_en       = 1'b1;
               cmd.rd_sel      = RD_FIRST;
               cmd.child_first = 1'b1;
               state_in        = S_DN_CHILD;
            end
         end
         S_DN_CHILD: begin
            cmd.best_upd = 1'b1;
            if (stat.more_child) begin
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_NEXT;
               cmd.child_next = 1'b1;
            end else begin
               state_in = S_DN_DECIDE;
            end
         end
         S_DN_DECIDE: begin
            cmd.wr_en = 1'b1;
            if (stat.best_lt_key) begin
               cmd.wr_sel    = WR_BEST;
               cmd.move_down = 1'b1;
               state_in      = S_DN_FIRST;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end
         end
         // Decrease: refuse a key larger than the one stored.
         S_DEC_CMP: begin
            if (stat.rdata_lt_key) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_IGNORED;
               state_in       = S_DONE;
            end else begin
               state_in = S_UP_CHECK;
            end
         end
         // Sift up: the hole climbs while the key is strictly below the parent.
         S_UP_CHECK: begin
            if (stat.cur_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end else begin
               cmd.par_calc = 1'b1;
               state_in     = S_UP_RD;
            end
         end
         S_UP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PARENT;
            state_in   = S_UP_CMP;
         end
         S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.key_lt_rdata) begin
               cmd.wr_sel  = WR_RDATA;
               cmd.move_up = 1'b1;
               state_in    = S_UP_CHECK;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: hw/rtl/ternary_min_heap_queue.sv
`timescale 1ns / 1ps

// Channel   Handshake            Fields
// item      start, busy          req_func, req_key, req_position
// result    rsp_valid (strobe)   rsp_result_key, rsp_status, rsp_entries
//
// One item is worked at a time; busy is high while it is being worked.
// Insert climbs from the new last entry; per level it finds the parent index, reads the parent and compares.
// Decrease-key checks the stored key, then climbs like insert; refused items and no-ops just respond.
// Extract reads the root and the last entry, then per level reads up to three children and decides.
// rsp_valid is in the first cycle with busy low; the next item may be taken in that cycle.
// Reset empties the queue at once; the memory needs no clearing pass; the receiver cannot stall.

module ternary_min_heap_queue #(
   parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tmhq_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [tmhq_pkg::KEY_W-1:0]  req_key,
   input  logic [tmhq_pkg::POS_W-1:0]         req_position,
   output logic                               rsp_valid,
   output logic signed [tmhq_pkg::KEY_W-1:0]  rsp_result_key,
   output logic [tmhq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tmhq_pkg::ENTRIES_W-1:0]     rsp_entries
);

   import tmhq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer for the sift loops.
   tmhq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Heap memory, count and index arithmetic.
   tmhq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_position   (req_position),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_result_key (rsp_result_key),
      .rsp_status     (rsp_status),
      .rsp_entries    (rsp_entries)
   );

endmodule

FILE: tb/ternary_min_heap_queue_tb.sv
`timescale 1ns / 1ps

module ternary_min_heap_queue_tb;
   import tmhq_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int NUM_DIRECTED = 26;
   localparam int PHASE_ITEMS  = 620;
   localparam int DRAIN_CYCLES = 40;
   localparam int DRAIN_LIMIT  = 4000;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct packed {
      logic signed [KEY_W-1:0] result_key;
      status_type              status;
      logic [ENTRIES_W-1:0]    entries;
   } heap_result_type;

   // One row of the directed table. A row marked fixed carries its expected result;
   // a row marked same_key decreases an entry to the key it already holds.
   typedef struct packed {
      func_type                func;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        position;
      logic                    same_key;
      logic                    fixed;
      heap_result_type         result;
   } stim_row_type;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } burst_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [FUNC_W-1:0]       req_func;
   logic signed [KEY_W-1:0] req_key;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_valid;
   logic signed [KEY_W-1:0] rsp_result_key;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ENTRIES_W-1:0]    rsp_entries;

   // Shadow copy of the heap, kept in step with every accepted item.
   logic signed [KEY_W-1:0] heap_model [CAPACITY];
   int                      entry_count;
   int                      high_water;

   heap_result_type         pending_results [$];
   heap_result_type         want;
   stim_row_type            directed [NUM_DIRECTED];
   int                      idle_pct;
   int                      fail_count;

   ternary_min_heap_queue #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_result_key (rsp_result_key),
      .rsp_status     (rsp_status),
      .rsp_entries    (rsp_entries)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Apply one operation to the shadow heap and return the result it produces.
   function automatic heap_result_type heap_apply(input func_type func,
                                                  input logic signed [KEY_W-1:0] key,
                                                  input logic [POS_W-1:0] position);
      heap_result_type         res;
      int                      idx;
      int                      parent;
      int                      first;
      int                      best;
      int                      j;
      logic signed [KEY_W-1:0] tmp;
      logic                    done;
      res.result_key = '0;
      res.status     = ST_OK;
      idx            = -1;
      case (func)
         FN_INSERT: begin
            if (entry_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               heap_model[entry_count] = key;
               idx = entry_count;
               entry_count++;
               if (entry_count > high_water) high_water = entry_count;
            end
         end
         FN_EXTRACT: begin
            if (entry_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.result_key = heap_model[0];
               heap_model[0] = heap_model[entry_count-1];
               entry_count--;
               // Sift the moved entry down toward the smallest child; ties keep the
               // lowest index and equal keys do not swap.
               idx  = 0;
               done = 1'b0;
               while (!done) begin
                  first = idx * 3 + 1;
                  if (first >= entry_count) begin
                     done = 1'b1;
                  end else begin
                     best = first;
                     for (j = first + 1; j <= first + 2 && j < entry_count; j++) begin
                        if (heap_model[j] < heap_model[best]) best = j;
                     end
                     if (heap_model[best] < heap_model[idx]) begin
                        tmp              = heap_model[idx];
                        heap_model[idx]  = heap_model[best];
                        heap_model[best] = tmp;
                        idx              = best;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               idx = -1;
            end
         end
         FN_DECREASE: begin
            if (int'(position) >= entry_count || heap_model[position] < key) begin
               res.status = ST_IGNORED;
            end else begin
               heap_model[position] = key;
               idx = position;
            end
         end
         default: begin
         end
      endcase
      // Sift up while strictly smaller than the parent.
      while (idx > 0) begin
         parent = (idx - 1) / 3;
         if (heap_model[idx] < heap_model[parent]) begin
            tmp                = heap_model[idx];
            heap_model[idx]    = heap_model[parent];
            heap_model[parent] = tmp;
            idx                = parent;
         end else begin
            idx = 0;
         end
      end
      res.entries = entry_count[ENTRIES_W-1:0];
      return res;
   endfunction

   // Keys lean toward the extremes and a narrow band around zero to force ties.
   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(9))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2, 3, 4: return KEY_W'($urandom_range(16) - 8);
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Present one item, wait for it to be taken and record what it should produce.
   task automatic send_item(input func_type func, input logic signed [KEY_W-1:0] key,
                            input logic [POS_W-1:0] position, input logic fixed,
                            input heap_result_type fixed_result);
      heap_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start        = 1'b1;
      req_func     = func;
      req_key      = key;
      req_position = position;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = heap_apply(func, key, position);
      pending_results.push_back(fixed ? fixed_result : predicted);
      @(negedge clock);
   endtask

   // Build one random item whose mix of operations follows the burst mode.
   task automatic make_item(input burst_mode_type mode, output func_type func,
                            output logic signed [KEY_W-1:0] key,
                            output logic [POS_W-1:0] position);
      int                      r;
      longint                  span;
      logic signed [KEY_W-1:0] cur;
      r        = $urandom_range(99);
      key      = pick_key();
      position = POS_W'($urandom);
      case (mode)
         MODE_FILL:  func = (r < 85) ? FN_INSERT : (r < 95) ? FN_DECREASE :
                            (r < 98) ? FN_EXTRACT : FN_NOP;
         MODE_DRAIN: func = (r < 80) ? FN_EXTRACT : (r < 92) ? FN_DECREASE :
                            (r < 96) ? FN_INSERT : FN_NOP;
         default:    func = (r < 40) ? FN_INSERT : (r < 75) ? FN_EXTRACT :
                            (r < 95) ? FN_DECREASE : FN_NOP;
      endcase
      if (func == FN_DECREASE) begin
         if (entry_count > 0 && (entry_count >= high_water || $urandom_range(9) < 8)) begin
            // A position in use, with an equal, arbitrary or smaller key.
            position = POS_W'($urandom_range(entry_count - 1));
            cur      = heap_model[position];
            span     = longint'(cur) - longint'(KEY_MIN) + 1;
            case ($urandom_range(5))
               0:       key = cur;
               1:       key = pick_key();
               2, 3:    key = KEY_W'(longint'(cur) - longint'($urandom_range(8)) % span);
               default: key = KEY_W'(longint'(cur) - longint'({32'b0, $urandom}) % span);
            endcase
         end else if (high_water > entry_count) begin
            // Past the count, but only over entries that have been written.
            position = POS_W'($urandom_range(high_water - 1, entry_count));
         end else begin
            func = FN_INSERT;
         end
      end
   endtask

   // One phase of random traffic: bursts that fill, drain or mix the heap.
   task automatic run_phase(input int pct, input int num_items);
      int                      sent;
      int                      burst;
      burst_mode_type          mode;
      func_type                func;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        position;
      idle_pct = pct;
      sent     = 0;
      mode     = MODE_FILL;
      burst    = 180;
      while (sent < num_items) begin
         // The last burst stops at the item count of the phase.
         if (burst > num_items - sent) burst = num_items - sent;
         repeat (burst) begin
            make_item(mode, func, key, position);
            send_item(func, key, position, 1'b0, '0);
            sent++;
         end
         mode  = burst_mode_type'($urandom_range(2));
         burst = $urandom_range(160, 20);
      end
   endtask

   // Compare each result item with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: result_key %0d status %0d entries %0d",
                   rsp_result_key, rsp_status, rsp_entries);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_key !== want.result_key) begin
               $error("rsp_result_key: expected %0d, actual %0d", want.result_key,
                      rsp_result_key);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_entries !== want.entries) begin
               $error("rsp_entries: expected %0d, actual %0d", want.entries, rsp_entries);
               fail_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, three random phases, drain.
   initial begin
      int k;
      int waited;
      logic signed [KEY_W-1:0] key;
      reset        = 1'b1;
      start        = 1'b0;
      req_func     = FN_NOP;
      req_key      = '0;
      req_position = '0;
      entry_count  = 0;
      high_water   = 0;
      fail_count   = 0;
      idle_pct     = 21;

      directed = '{
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_EMPTY,   8'd0}},
         '{FN_NOP,      -32'sd1, 7'd127, 1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd0}},
         '{FN_INSERT,   KEY_MAX, 7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd1}},
         '{FN_INSERT,   KEY_MIN, 7'd127, 1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd2}},
         '{FN_INSERT,   32'sd0,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd3}},
         '{FN_INSERT,   -32'sd1, 7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd4}},
         '{FN_INSERT,   32'sd5,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd5}},
         '{FN_INSERT,   32'sd5,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd6}},
         '{FN_INSERT,   32'sd3,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd7}},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b1, '{KEY_MIN, ST_OK,      8'd6}},
         // Position equal to the count: ignored.
         '{FN_DECREASE, KEY_MIN, 7'd6,   1'b0, 1'b1, '{32'sd0,  ST_IGNORED, 8'd6}},
         // Larger key, equal key at the root, then the root to the minimum.
         '{FN_DECREASE, KEY_MAX, 7'd3,   1'b0, 1'b0, '0},
         '{FN_DECREASE, 32'sd0,  7'd0,   1'b1, 1'b0, '0},
         '{FN_DECREASE, KEY_MIN, 7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd6}},
         // A tie with the root must not climb past it.
         '{FN_DECREASE, KEY_MIN, 7'd5,   1'b0, 1'b0, '0},
         '{FN_DECREASE, 32'sd0,  7'd4,   1'b1, 1'b0, '0},
         '{FN_DECREASE, -32'sd2, 7'd2,   1'b0, 1'b0, '0},
         '{FN_INSERT,   KEY_MIN, 7'd0,   1'b0, 1'b1, '{32'sd0,  ST_OK,      8'd7}},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b1, '{KEY_MIN, ST_OK,      8'd6}},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b0, '0},
         '{FN_EXTRACT,  32'sd0,  7'd0,   1'b0, 1'b1, '{32'sd0,  ST_EMPTY,   8'd0}}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < NUM_DIRECTED; k++) begin
         key = directed[k].same_key ? heap_model[directed[k].position] : directed[k].key;
         send_item(directed[k].func, key, directed[k].position, directed[k].fixed,
                   directed[k].result);
      end

      run_phase(21, PHASE_ITEMS);
      run_phase(83, PHASE_ITEMS);
      run_phase(0, PHASE_ITEMS);
      start = 1'b0;

      // Let the last results arrive, then watch a little longer for stray ones.
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d result items never arrived", pending_results.size());
         fail_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
